[src/bdel_pkg.sv]
package bdel_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF      = 8;
  localparam int MAX_SEGMENT_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int PIXEL_W    = 8;
  localparam int BASE_W     = 12;
  localparam int THR_W      = 12;
  localparam int COORD_W    = 13;
  localparam int SUM_W      = 12;
  localparam int CONTRAST_W = 13;

  localparam logic [THR_W-1:0] THR_RESET = 12'd200;

  typedef struct packed {
    logic [PIXEL_W-1:0] gray_pixel;
    logic [BASE_W-1:0]  segment_base;
    logic               rising_edge;
    logic               last_pixel;
  } bdel_in_t;

  typedef struct packed {
    logic               edge_found;
    logic [COORD_W-1:0] edge_coordinate;
  } bdel_out_t;

  // Classified pixel word handed from the front to the back
  typedef struct packed {
    logic [PIXEL_W-1:0] gray_pixel;
    logic [BASE_W-1:0]  segment_base;
    logic               rising_edge;
    logic [THR_W-1:0]   threshold;
    logic               first;
    logic               last_pixel;
    logic               update;
    logic               eval;
    logic [COORD_W-1:0] index;
  } bdel_cmd_t;

endpackage

[src/box_difference_edge_locator.sv]
// Box-difference step-edge locator for one row or column segment. Feed one
// grayscale pixel word per cycle; flag the final pixel with last_pixel. The
// first word of a segment sets the base coordinate and the edge direction and
// latches the contrast threshold. Around each candidate position the block sums
// WINDOW pixels before and after it and keeps the position of the highest
// contrast that strictly beats the threshold, the earliest one on a tie. The
// closing word returns one result: edge_found and base plus index (mod 8192),
// or zero when no edge. Throughput is one pixel per cycle while in_stall is
// low, set by the back end's update of the two running sums; a result passes
// through the queue and then the result register. A QUEUE_DEPTH-word queue
// sits between the front end (accept, count, classify) and the back end (sums,
// compare, result register), so a stalled result only backs up the input once
// the queue fills. No clearing pass after reset: the block takes words right away.
module box_difference_edge_locator #(
  parameter int WINDOW      = bdel_pkg::WINDOW_DEF,
  parameter int MAX_SEGMENT = bdel_pkg::MAX_SEGMENT_DEF,
  parameter int QUEUE_DEPTH = bdel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bdel_pkg::THR_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bdel_pkg::bdel_in_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bdel_pkg::bdel_out_t        out_word
);

  // Front-to-queue and queue-to-back control
  logic                q_full;
  logic                q_push;
  logic                q_empty;
  logic                q_pop;
  bdel_pkg::bdel_cmd_t push_cmd;
  bdel_pkg::bdel_cmd_t head_cmd;

  // Accept, count pixels, tag first/update/evaluate, latch threshold
  bdel_front #(
    .WINDOW      (WINDOW),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // Hold classified words until the back end drains them
  bdel_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  // Advance delay line and sums, track the best candidate, emit results
  bdel_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[src/bdel_front.sv]
module bdel_front #(
  parameter int WINDOW      = bdel_pkg::WINDOW_DEF,
  parameter int MAX_SEGMENT = bdel_pkg::MAX_SEGMENT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bdel_pkg::THR_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bdel_pkg::bdel_in_t         in_word,
  input  logic                       q_full,
  output logic                       q_push,
  output bdel_pkg::bdel_cmd_t        q_cmd
);

  localparam int CNT_MAX = (MAX_SEGMENT > 2 * WINDOW) ? MAX_SEGMENT : 2 * WINDOW;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  logic [bdel_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       update;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign update   = !in_word.last_pixel && (count_r < CNT_W'(MAX_SEGMENT));

  always_comb begin
    q_cmd.gray_pixel   = in_word.gray_pixel;
    q_cmd.segment_base = in_word.segment_base;
    q_cmd.rising_edge  = in_word.rising_edge;
    q_cmd.threshold    = thr_r;
    q_cmd.first        = (count_r == '0);
    q_cmd.last_pixel   = in_word.last_pixel;
    q_cmd.update       = update;
    q_cmd.eval         = update && (count_r >= CNT_W'(2 * WINDOW));
    q_cmd.index        = bdel_pkg::COORD_W'(count_r - CNT_W'(WINDOW));
  end

  always_comb begin
    thr_nxt   = cfg_wr_en ? cfg_wr_data : thr_r;
    count_nxt = count_r;
    if (q_push) begin
      if (in_word.last_pixel) begin
        count_nxt = '0;
      end else if (update) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= bdel_pkg::THR_RESET;
      count_r <= '0;
    end else begin
      thr_r   <= thr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[src/bdel_queue.sv]
module bdel_queue #(
  parameter int DEPTH = bdel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bdel_pkg::bdel_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output bdel_pkg::bdel_cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bdel_pkg::bdel_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[src/bdel_back.sv]
module bdel_back #(
  parameter int WINDOW = bdel_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  bdel_pkg::bdel_cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bdel_pkg::bdel_out_t out_word
);

  localparam int LINE_LEN = 2 * WINDOW;
  localparam int PW = bdel_pkg::PIXEL_W;
  localparam int SW = bdel_pkg::SUM_W;
  localparam int CW = bdel_pkg::CONTRAST_W;
  localparam int XW = bdel_pkg::COORD_W;

  logic [PW-1:0]             line_r   [LINE_LEN];
  logic [PW-1:0]             line_nxt [LINE_LEN];
  logic [SW-1:0]             before_r, before_nxt, before_upd;
  logic [SW-1:0]             after_r, after_nxt, after_upd;
  logic signed [CW-1:0]      best_r, best_nxt, best_base, contrast;
  logic [XW-1:0]             idx_r, idx_nxt, idx_base;
  logic                      have_r, have_nxt, have_base;
  logic [bdel_pkg::BASE_W-1:0] base_r, base_nxt;
  logic                      rising_r, rising_nxt;
  logic                      better;
  logic                      out_valid_r, out_valid_nxt;
  bdel_pkg::bdel_out_t       out_word_r, out_word_nxt;
  logic [PW-1:0]             mid, old;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Hold a closing word while the previous result still waits
  assign q_pop = !q_empty && (!q_head.last_pixel || !out_valid_r || !out_stall);

  assign mid = line_r[WINDOW-1];
  assign old = line_r[LINE_LEN-1];

  always_comb begin
    base_nxt   = q_head.first ? q_head.segment_base : base_r;
    rising_nxt = q_head.first ? q_head.rising_edge : rising_r;
    best_base  = q_head.first ? signed'(CW'(q_head.threshold)) : best_r;
    idx_base   = q_head.first ? '0 : idx_r;
    have_base  = q_head.first ? 1'b0 : have_r;

    after_upd  = after_r + SW'(q_head.gray_pixel) - SW'(mid);
    before_upd = before_r + SW'(mid) - SW'(old);
    contrast   = rising_nxt ? signed'(CW'(after_upd) - CW'(before_upd))
                            : signed'(CW'(before_upd) - CW'(after_upd));
    better     = q_head.eval && (contrast > best_base);
  end

  always_comb begin
    line_nxt      = line_r;
    before_nxt    = before_r;
    after_nxt     = after_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    have_nxt      = have_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      best_nxt = better ? contrast : best_base;
      idx_nxt  = better ? q_head.index : idx_base;
      have_nxt = better || have_base;
      if (q_head.last_pixel) begin
        for (int k = 0; k < LINE_LEN; k++) begin
          line_nxt[k] = '0;
        end
        before_nxt    = '0;
        after_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_word_nxt.edge_found      = have_base;
        out_word_nxt.edge_coordinate = have_base ? XW'(base_nxt) + idx_base : '0;
      end else if (q_head.update) begin
        for (int k = 1; k < LINE_LEN; k++) begin
          line_nxt[k] = line_r[k-1];
        end
        line_nxt[0] = q_head.gray_pixel;
        before_nxt  = before_upd;
        after_nxt   = after_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        line_r[k] <= '0;
      end
      before_r    <= '0;
      after_r     <= '0;
      best_r      <= '0;
      idx_r       <= '0;
      have_r      <= 1'b0;
      base_r      <= '0;
      rising_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      before_r    <= before_nxt;
      after_r     <= after_nxt;
      best_r      <= best_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
      base_r      <= q_pop ? base_nxt : base_r;
      rising_r    <= q_pop ? rising_nxt : rising_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

[src/bdel_checker.sv]
module bdel_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bdel_pkg::bdel_out_t out_word
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // No edge means coordinate zero
  a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.edge_found |-> out_word.edge_coordinate == '0)
    else $error("coordinate nonzero without an edge");

  // Reset drops any pending result
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the queue, so input is open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind box_difference_edge_locator bdel_checker u_bdel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
